// ===== design/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge while the disable term is low.
`define ASSERT_CLK(label, clk, dis, prop) \
  label: assert property (@(posedge clk) disable iff (dis) (prop)) \
    else $error("assertion failed: label");

// A signal holds its value across an edge at which the condition held.
`define ASSERT_HOLD(label, clk, dis, cond, sig) \
  label: assert property (@(posedge clk) disable iff (dis) (cond) |=> $stable(sig)) \
    else $error("assertion failed: label");

`endif

// ===== design/wibcd_pkg.sv =====
// Types, constants and the double-dabble step for the Wiegand id BCD packer.
package wibcd_pkg;

  localparam int unsigned CardBits  = 16;
  localparam int unsigned BcdWidth  = 20;
  localparam int unsigned FacWidth  = 12;
  localparam int unsigned NumCells  = CardBits;
  localparam logic [7:0]  MaxLength = 8'd6;
  localparam logic [3:0]  DigitMask = 4'hf;

  typedef struct packed {
    logic [23:0] card_bytes;
    logic [7:0]  length_field;
  } in_req_t;

  typedef struct packed {
    logic [31:0] packed_id;
    logic        status;
  } out_req_t;

  // State that travels down the row of cells.
  typedef struct packed {
    logic [CardBits-1:0] card_sh;
    logic [CardBits-1:0] fac_sh;
    logic [BcdWidth-1:0] card_bcd;
    logic [FacWidth-1:0] fac_bcd;
    logic                err;
  } cell_data_t;

  // One shift-and-add-3 step: correct every digit of five or more, then
  // shift in the next binary bit.
  function automatic logic [BcdWidth-1:0] dd_step(input logic [BcdWidth-1:0] bcd,
                                                  input logic bit_in);
    logic [BcdWidth-1:0] adj;
    adj = bcd;
    for (int d = 0; d < BcdWidth / 4; d++) begin
      if (adj[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = adj[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BcdWidth-2:0], bit_in};
  endfunction

endpackage

// ===== design/wibcd_cell.sv =====
// One double-dabble cell: a single conversion step on both lanes per request.
module wibcd_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  valid_up,
  input  wibcd_pkg::cell_data_t data_up,
  output logic                  ready_up,
  output logic                  valid_r,
  output wibcd_pkg::cell_data_t data_r,
  input  logic                  ready_dn
);

  logic                  valid_nxt;
  wibcd_pkg::cell_data_t data_nxt;
  logic [wibcd_pkg::BcdWidth-1:0] fac_wide;

  // Take a new request whenever this slot is empty or is draining below.
  assign ready_up = !valid_r || ready_dn;

  always_comb begin
    fac_wide = wibcd_pkg::dd_step({{(wibcd_pkg::BcdWidth - wibcd_pkg::FacWidth){1'b0}},
                                   data_up.fac_bcd},
                                  data_up.fac_sh[wibcd_pkg::CardBits-1]);
    data_nxt          = data_up;
    data_nxt.card_bcd = wibcd_pkg::dd_step(data_up.card_bcd,
                                           data_up.card_sh[wibcd_pkg::CardBits-1]);
    data_nxt.fac_bcd  = fac_wide[wibcd_pkg::FacWidth-1:0];
    data_nxt.card_sh  = {data_up.card_sh[wibcd_pkg::CardBits-2:0], 1'b0};
    data_nxt.fac_sh   = {data_up.fac_sh[wibcd_pkg::CardBits-2:0], 1'b0};
    valid_nxt         = ready_up ? valid_up : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== design/wiegand_id_bcd_packer_core.sv =====
// Top level of the Wiegand id BCD packer: a row of sixteen double-dabble cells.
// The result passes through all sixteen cell registers, one cell per card bit,
// and out_valid rises once the last cell holds it.
// Throughput: one request per cycle while out_stall is low; each cell holds one request in flight.
// The last cell is the output register; bubbles close up under out_stall.
// Reset (rst_n low, synchronous) empties every cell; payload is not reset.
module wiegand_id_bcd_packer_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  wibcd_pkg::in_req_t  in_req,
  output logic                out_valid,
  input  logic                out_stall,
  output wibcd_pkg::out_req_t out_req
);

  localparam int unsigned N = wibcd_pkg::NumCells;

  // Handshake wires between neighbors: index i feeds cell i.
  logic                  valid_c [N+1];
  logic                  ready_c [N+1];
  wibcd_pkg::cell_data_t data_c  [N+1];

  wibcd_pkg::cell_data_t last;
  logic [3:0]            fac_h, fac_t, fac_u;

  // Load the head of the row: facility lane zero-extended to the card width,
  // since leading zeros leave double dabble untouched.
  always_comb begin
    data_c[0].card_sh  = in_req.card_bytes[15:0];
    data_c[0].fac_sh   = {8'h00, in_req.card_bytes[23:16]};
    data_c[0].card_bcd = '0;
    data_c[0].fac_bcd  = '0;
    data_c[0].err      = in_req.length_field > wibcd_pkg::MaxLength;
  end

  assign valid_c[0] = in_valid;
  assign in_stall   = !ready_c[0];

  for (genvar i = 0; i < N; i++) begin : g_cell
    wibcd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .valid_up (valid_c[i]),
      .data_up  (data_c[i]),
      .ready_up (ready_c[i]),
      .valid_r  (valid_c[i+1]),
      .data_r   (data_c[i+1]),
      .ready_dn (ready_c[i+1])
    );
  end

  // The tail cell is the output register.
  assign ready_c[N] = !out_stall;
  assign out_valid  = valid_c[N];
  assign last       = data_c[N];

  assign fac_h = last.fac_bcd[11:8] & wibcd_pkg::DigitMask;
  assign fac_t = last.fac_bcd[7:4]  & wibcd_pkg::DigitMask;
  assign fac_u = last.fac_bcd[3:0]  & wibcd_pkg::DigitMask;

  // Pack little-endian: facility hundreds and tens lowest, card tens and units in the top byte.
  // Drop the id to zero on a length error.
  always_comb begin
    out_req.status = last.err;
    if (last.err) begin
      out_req.packed_id = '0;
    end else begin
      out_req.packed_id = {last.card_bcd[7:0], last.card_bcd[15:8],
                           fac_u, last.card_bcd[19:16], fac_h, fac_t};
    end
  end

endmodule

// ===== design/wibcd_checker.sv =====
// Port-level checker for the Wiegand id BCD packer, bound to the top level.
`include "assert_macros.svh"

module wibcd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input wibcd_pkg::in_req_t  in_req,
  input logic                out_valid,
  input logic                out_stall,
  input wibcd_pkg::out_req_t out_req
);

  logic [31:0] id;
  logic        digits_ok;

  assign id = out_req.packed_id;
  // Lowest byte is facility hundreds:tens, so the hundreds nibble sits at 7:4.
  assign digits_ok = (id[3:0] <= 4'd9) && (id[7:4] <= 4'd2) && (id[11:8] <= 4'd9)
                  && (id[15:12] <= 4'd9) && (id[19:16] <= 4'd9) && (id[23:20] <= 4'd9)
                  && (id[27:24] <= 4'd9) && (id[31:28] <= 4'd9);

  // A stalled request holds its payload.
  `ASSERT_HOLD(a_out_hold, clk, !rst_n, out_valid && out_stall, out_req)
  // A stalled input request keeps valid high and its payload unchanged.
  `ASSERT_HOLD(a_in_hold, clk, !rst_n, in_valid && in_stall, {in_valid, in_req})
  // An error request carries a zero id.
  `ASSERT_CLK(a_err_zero, clk, !rst_n, (out_valid && out_req.status) |-> (id == 32'h0))
  // Every digit of a good id is decimal, facility hundreds at most two.
  `ASSERT_CLK(a_bcd_ok, clk, !rst_n, (out_valid && !out_req.status) |-> digits_ok)
  // The row is empty right after reset, so nothing comes out then.
  `ASSERT_CLK(a_rst_empty, clk, 1'b0, !rst_n |=> !out_valid)

endmodule

bind wiegand_id_bcd_packer_core wibcd_checker u_wibcd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_req   (out_req)
);

// ===== test/wiegand_id_bcd_packer_core_test.sv =====
// Testbench for the Wiegand id BCD packer: directed and random card requests checked in order.
`timescale 1ns / 1ps

module wiegand_id_bcd_packer_core_test;

  // Status codes carried in out_req.status.
  localparam logic StatusOk          = 1'b0;
  localparam logic StatusLengthError = 1'b1;

  // Receiver hold-off long enough to fill all sixteen cells and stall the input.
  localparam int HoldOffCycles = 200;
  // Quiet cycles after the last result, before the final check.
  localparam int DrainCycles   = 40;
  // Run limit in ns, far beyond the slowest legal run.
  localparam int RunLimitNs    = 2_000_000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  wibcd_pkg::in_req_t  in_req    = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  wibcd_pkg::out_req_t out_req;

  // Idle rates in percent; the receiver rate is updated with NBAs only.
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  logic     holding       = 1'b0;

  wibcd_pkg::out_req_t pending_ids[$];
  wibcd_pkg::out_req_t oldest_id;
  int                  mismatch_count = 0;

  wiegand_id_bcd_packer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  always #2 clk = ~clk;

  // Compute the packed BCD id for one request. Digits come from plain
  // division here, so the check does not share the shift-and-add-3 scheme.
  function automatic wibcd_pkg::out_req_t pack_card_id(input wibcd_pkg::in_req_t req);
    wibcd_pkg::out_req_t res;
    int unsigned         fac_val;
    int unsigned         card_val;
    int unsigned         digit;
    logic [3:0]          fac_dig [3];
    logic [3:0]          card_dig [5];
    res.packed_id = '0;
    res.status    = StatusLengthError;
    if (req.length_field > wibcd_pkg::MaxLength) begin
      return res;
    end
    // Read the facility byte as unsigned; it always yields three digits.
    fac_val  = {24'd0, req.card_bytes[23:16]};
    card_val = {16'd0, req.card_bytes[15:0]};
    for (int i = 0; i < 3; i++) begin
      digit      = fac_val % 10;
      fac_dig[i] = digit[3:0];
      fac_val    = fac_val / 10;
    end
    for (int i = 0; i < 5; i++) begin
      digit       = card_val % 10;
      card_dig[i] = digit[3:0];
      card_val    = card_val / 10;
    end
    // First byte lowest: {hundreds,tens}, {units,d4}, {d3,d2}, {d1,d0}.
    res.packed_id = {card_dig[1], card_dig[0], card_dig[3], card_dig[2],
                     fac_dig[0], card_dig[4], fac_dig[2], fac_dig[1]};
    res.status    = StatusOk;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Record each accepted request and check each accepted result against the
  // oldest outstanding id. Sample at the edge, before any NBA lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        pending_ids.push_back(pack_card_id(in_req));
      end
      if (out_valid && !out_stall) begin
        if (pending_ids.size() == 0) begin
          report_mismatch($sformatf("result %h/%b with no request outstanding",
                                    out_req.packed_id, out_req.status));
        end else begin
          oldest_id = pending_ids.pop_front();
          if (out_req.packed_id !== oldest_id.packed_id) begin
            report_mismatch($sformatf("packed_id %h, want %h",
                                      out_req.packed_id, oldest_id.packed_id));
          end
          if (out_req.status !== oldest_id.status) begin
            report_mismatch($sformatf("status %b, want %b",
                                      out_req.status, oldest_id.status));
          end
        end
      end
    end
  end

  // Drive out_stall: random stalls at the current rate, plus any hold-off.
  always @(posedge clk) begin
    out_stall <= holding || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Offer one request: idle at random first, then hold valid and payload
  // until the edge that accepts it. Valid stays high on return, so a
  // back-to-back request replaces the payload without a bubble.
  task automatic offer_request(input wibcd_pkg::in_req_t req);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  task automatic offer_fields(input logic [7:0] fac, input logic [15:0] card,
                              input logic [7:0] len);
    wibcd_pkg::in_req_t req;
    req.card_bytes   = {fac, card};
    req.length_field = len;
    offer_request(req);
  endtask

  // Drop valid and wait until every outstanding id has come back.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_ids.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Pick values that sit on decimal digit rollovers.
  function automatic logic [15:0] card_corner(input int unsigned idx);
    case (idx)
      0:       return 16'd0;
      1:       return 16'd9;
      2:       return 16'd10;
      3:       return 16'd99;
      4:       return 16'd100;
      5:       return 16'd999;
      6:       return 16'd1000;
      7:       return 16'd9999;
      8:       return 16'd10000;
      9:       return 16'd59999;
      10:      return 16'd65534;
      default: return 16'd65535;
    endcase
  endfunction

  function automatic logic [7:0] fac_corner(input int unsigned idx);
    case (idx)
      0:       return 8'd0;
      1:       return 8'd9;
      2:       return 8'd10;
      3:       return 8'd99;
      4:       return 8'd100;
      5:       return 8'd199;
      6:       return 8'd200;
      default: return 8'd255;
    endcase
  endfunction

  function automatic wibcd_pkg::in_req_t random_card_request();
    wibcd_pkg::in_req_t req;
    logic [7:0]         fac;
    logic [15:0]        card;
    logic [7:0]         len;
    fac  = 8'($urandom);
    card = 16'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      fac = fac_corner($urandom_range(0, 7));
    end
    if ($urandom_range(0, 3) == 0) begin
      card = card_corner($urandom_range(0, 11));
    end
    // Keep most lengths legal so the conversion path gets most of the traffic.
    case ($urandom_range(0, 9))
      0, 1:    len = 8'($urandom_range(7, 255));
      2:       len = $urandom_range(0, 1) ? wibcd_pkg::MaxLength : 8'd0;
      default: len = 8'($urandom_range(0, 6));
    endcase
    req.card_bytes   = {fac, card};
    req.length_field = len;
    return req;
  endfunction

  // Walk the digit rollovers of both the facility code and the card number.
  task automatic test_digit_boundaries();
    offer_fields(8'd0,   16'd0,     8'd0);
    offer_fields(8'd255, 16'd65535, wibcd_pkg::MaxLength);
    offer_fields(8'd9,   16'd9,     8'd1);
    offer_fields(8'd10,  16'd10,    8'd2);
    offer_fields(8'd99,  16'd99,    8'd3);
    offer_fields(8'd100, 16'd100,   8'd4);
    offer_fields(8'd199, 16'd999,   8'd5);
    offer_fields(8'd200, 16'd1000,  8'd6);
    offer_fields(8'd128, 16'd9999,  8'd0);
    offer_fields(8'd127, 16'd10000, 8'd3);
    offer_fields(8'd1,   16'd65534, 8'd6);
    offer_fields(8'd170, 16'hAAAA,  8'd2);
    offer_fields(8'd85,  16'h5555,  8'd1);
  endtask

  // Lengths past the limit and at the top clear the id and flag status; one legal request sits at the limit.
  task automatic test_length_limit();
    offer_fields(8'd255, 16'd65535, 8'd7);
    offer_fields(8'd0,   16'd0,     8'd255);
    offer_fields(8'd123, 16'd45678, 8'd128);
    offer_fields(8'd200, 16'd12345, 8'd8);
    offer_fields(8'd50,  16'd54321, wibcd_pkg::MaxLength);
    offer_fields(8'd77,  16'd31415, 8'd7);
  endtask

  task automatic test_random_cards(input int count);
    for (int i = 0; i < count; i++) begin
      offer_request(random_card_request());
    end
  endtask

  // Hold the receiver off for a long stretch while requests keep coming,
  // so the cells fill and the input stalls, then let it all drain.
  task automatic test_input_backpressure();
    send_idle_pct = 0;
    fork
      begin
        holding <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk);
        holding <= 1'b0;
      end
    join_none
    test_random_cards(60);
    pause_until_drained();
  endtask

  initial begin
    // Hold reset, then release it once.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles 29 percent, receiver 50.
    send_idle_pct = 29;
    recv_idle_pct <= 50;
    test_digit_boundaries();
    test_length_limit();
    test_random_cards(400);
    pause_until_drained();

    // Swap the rates.
    send_idle_pct = 50;
    recv_idle_pct <= 29;
    test_random_cards(400);
    pause_until_drained();

    // Full rate on both sides, then the long hold-off.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_random_cards(340);
    pause_until_drained();
    test_input_backpressure();

    repeat (DrainCycles) @(posedge clk);
    if (pending_ids.size() != 0) begin
      report_mismatch($sformatf("%0d ids never returned", pending_ids.size()));
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(RunLimitNs);
    $display("status: fail");
    $finish;
  end

endmodule
